@@ sv/gbc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the gyro bias calibrator.
// Used by the channel interfaces, the controller, the datapath and the divider lanes.
package gbc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = SAMPLE_W + COUNT_W;
  localparam int FIX_W    = SAMPLE_W + 1;
  localparam int THR_W    = 23;
  localparam int TARGET_W = 16;
  localparam int CFG_W    = (THR_W > TARGET_W) ? THR_W : TARGET_W;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W   = $clog2(SAMPLE_W);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 1'd1;

  localparam logic [THR_W-1:0]    THRESHOLD_RST = THR_W'(1024);
  localparam logic [TARGET_W-1:0] TARGET_RST    = TARGET_W'(2000);
  localparam logic [COUNT_W-1:0]  REJECT_MIN    = COUNT_W'(20);
  localparam logic [COUNT_W-1:0]  COUNT_MAX     = '1;

  localparam logic signed [SAMPLE_W-1:0] OFFSET_X_RST = SAMPLE_W'(-3000);
  localparam logic signed [SAMPLE_W-1:0] OFFSET_Y_RST = SAMPLE_W'(-4000);
  localparam logic signed [SAMPLE_W-1:0] OFFSET_Z_RST = SAMPLE_W'(-2000);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_COMPARE,
    ST_ADD,
    ST_TARGET,
    ST_OFFSET,
    ST_UPDATE,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic clear_acc;
    logic div_load;
    logic div_step;
    logic accumulate;
    logic write_offset;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_rest;
    logic count_above_min;
    logic reject;
    logic target_hit;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/gbc_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: one beat carries three gyro samples and the at-rest flag.
// Depends on gbc_pkg for the sample width.
interface gbc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gbc_pkg::SAMPLE_W-1:0]  rate_x;
  logic signed [gbc_pkg::SAMPLE_W-1:0]  rate_y;
  logic signed [gbc_pkg::SAMPLE_W-1:0]  rate_z;
  logic                                 at_rest;

  modport source (output valid, rate_x, rate_y, rate_z, at_rest, input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, at_rest, output ready);
endinterface

@@ sv/gbc_out_if.sv @@
`timescale 1ns / 1ps
// Output channel: one beat carries the done flag, the biases and the corrected rates.
// Depends on gbc_pkg for the field widths.
interface gbc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 done_res;
  logic signed [gbc_pkg::SAMPLE_W-1:0]  bias_x;
  logic signed [gbc_pkg::SAMPLE_W-1:0]  bias_y;
  logic signed [gbc_pkg::SAMPLE_W-1:0]  bias_z;
  logic signed [gbc_pkg::FIX_W-1:0]     fixed_x;
  logic signed [gbc_pkg::FIX_W-1:0]     fixed_y;
  logic signed [gbc_pkg::FIX_W-1:0]     fixed_z;

  modport source (output valid, done_res, bias_x, bias_y, bias_z, fixed_x, fixed_y, fixed_z,
                  input ready);
  modport sink (input valid, done_res, bias_x, bias_y, bias_z, fixed_x, fixed_y, fixed_z,
                output ready);
endinterface

@@ sv/gbc_div.sv @@
`timescale 1ns / 1ps
// One divider lane: signed sum over unsigned count, truncated toward zero, one bit per step.
// Depends on gbc_pkg for widths.
module gbc_div (
  input  logic                                clk,
  input  logic                                load,
  input  logic                                step,
  input  logic signed [gbc_pkg::SUM_W-1:0]    dividend,
  input  logic [gbc_pkg::COUNT_W-1:0]         divisor,
  output logic signed [gbc_pkg::SAMPLE_W-1:0] quotient
);

  logic                             neg;
  logic [gbc_pkg::COUNT_W-1:0]      dvs;
  logic [gbc_pkg::COUNT_W-1:0]      rem;
  logic [gbc_pkg::SAMPLE_W-1:0]     quo;
  logic [gbc_pkg::SUM_W-1:0]        mag;
  logic [gbc_pkg::COUNT_W:0]        trial;
  logic [gbc_pkg::COUNT_W:0]        diff;
  logic                             ge;
  logic [gbc_pkg::SAMPLE_W-1:0]     quo_neg;

  // A mean never leaves the sample range, so the upper dividend bits are already a remainder.
  assign mag     = dividend[gbc_pkg::SUM_W-1] ? ('0 - dividend) : dividend;
  assign trial   = {rem, quo[gbc_pkg::SAMPLE_W-1]};
  assign diff    = trial - {1'b0, dvs};
  assign ge      = (trial >= {1'b0, dvs});
  assign quo_neg = '0 - quo;
  assign quotient = neg ? quo_neg : quo;

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= dividend[gbc_pkg::SUM_W-1];
      dvs <= divisor;
      rem <= mag[gbc_pkg::SUM_W-1:gbc_pkg::SAMPLE_W];
      quo <= mag[gbc_pkg::SAMPLE_W-1:0];
    end else if (step) begin
      rem <= ge ? diff[gbc_pkg::COUNT_W-1:0] : trial[gbc_pkg::COUNT_W-1:0];
      quo <= {quo[gbc_pkg::SAMPLE_W-2:0], ge};
    end
  end

endmodule

@@ sv/gbc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences capture, deviation check, accumulation,
// bias update and result hand-off. Depends on gbc_pkg.
module gbc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  gbc_pkg::dp_status_t    status,
  output gbc_pkg::ctrl_cmd_t     cmd
);

  gbc_pkg::ctrl_state_t          state, state_next;
  logic [gbc_pkg::STEP_W-1:0]    step_cnt, step_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gbc_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      gbc_pkg::ST_IDLE: begin
        if (!rst) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_next  = gbc_pkg::ST_DECIDE;
          end
        end
      end
      gbc_pkg::ST_DECIDE: begin
        if (!status.at_rest) begin
          cmd.clear_acc = 1'b1;
          state_next    = gbc_pkg::ST_FINISH;
        end else if (status.count_above_min) begin
          cmd.div_load  = 1'b1;
          step_cnt_next = gbc_pkg::LAST_STEP;
          state_next    = gbc_pkg::ST_CHECK;
        end else begin
          state_next = gbc_pkg::ST_ADD;
        end
      end
      gbc_pkg::ST_CHECK: begin
        cmd.div_step = 1'b1;
        if (step_cnt == '0) begin
          state_next = gbc_pkg::ST_COMPARE;
        end else begin
          step_cnt_next = step_cnt - 1'b1;
        end
      end
      gbc_pkg::ST_COMPARE: begin
        if (status.reject) begin
          cmd.clear_acc = 1'b1;
          state_next    = gbc_pkg::ST_FINISH;
        end else begin
          state_next = gbc_pkg::ST_ADD;
        end
      end
      gbc_pkg::ST_ADD: begin
        cmd.accumulate = 1'b1;
        state_next     = gbc_pkg::ST_TARGET;
      end
      gbc_pkg::ST_TARGET: begin
        if (status.target_hit) begin
          cmd.div_load  = 1'b1;
          step_cnt_next = gbc_pkg::LAST_STEP;
          state_next    = gbc_pkg::ST_OFFSET;
        end else begin
          state_next = gbc_pkg::ST_FINISH;
        end
      end
      gbc_pkg::ST_OFFSET: begin
        cmd.div_step = 1'b1;
        if (step_cnt == '0) begin
          state_next = gbc_pkg::ST_UPDATE;
        end else begin
          step_cnt_next = step_cnt - 1'b1;
        end
      end
      gbc_pkg::ST_UPDATE: begin
        cmd.write_offset = 1'b1;
        cmd.clear_acc    = 1'b1;
        state_next       = gbc_pkg::ST_FINISH;
      end
      gbc_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = gbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gbc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/gbc_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: sample capture, per-axis sums and count, three divider lanes,
// bias registers, configuration registers and the output register. Depends on gbc_pkg, gbc_div.
module gbc_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [gbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gbc_pkg::CFG_W-1:0]            cfg_data,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0]  rate_x,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0]  rate_y,
  input  logic signed [gbc_pkg::SAMPLE_W-1:0]  rate_z,
  input  logic                                 at_rest,
  input  gbc_pkg::ctrl_cmd_t                   cmd,
  output gbc_pkg::dp_status_t                  status,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 done_res,
  output logic signed [gbc_pkg::SAMPLE_W-1:0]  bias_x,
  output logic signed [gbc_pkg::SAMPLE_W-1:0]  bias_y,
  output logic signed [gbc_pkg::SAMPLE_W-1:0]  bias_z,
  output logic signed [gbc_pkg::FIX_W-1:0]     fixed_x,
  output logic signed [gbc_pkg::FIX_W-1:0]     fixed_y,
  output logic signed [gbc_pkg::FIX_W-1:0]     fixed_z
);

  logic [gbc_pkg::THR_W-1:0]            threshold;
  logic [gbc_pkg::TARGET_W-1:0]         target;
  logic signed [gbc_pkg::SAMPLE_W-1:0]  smp_x, smp_y, smp_z;
  logic                                 rest;
  logic signed [gbc_pkg::SUM_W-1:0]     sum_x, sum_y, sum_z;
  logic [gbc_pkg::COUNT_W-1:0]          sample_count;
  logic signed [gbc_pkg::SAMPLE_W-1:0]  offset_x, offset_y, offset_z;
  logic                                 done_flag;
  logic signed [gbc_pkg::SAMPLE_W-1:0]  mean_x, mean_y, mean_z;

  function automatic logic exceeds(input logic signed [gbc_pkg::SAMPLE_W-1:0] s,
                                   input logic signed [gbc_pkg::SAMPLE_W-1:0] m,
                                   input logic [gbc_pkg::THR_W-1:0] t);
    logic signed [gbc_pkg::FIX_W-1:0] d;
    logic [gbc_pkg::FIX_W-1:0]        a;
    d = gbc_pkg::FIX_W'(s) - gbc_pkg::FIX_W'(m);
    a = d[gbc_pkg::FIX_W-1] ? gbc_pkg::FIX_W'(-d) : gbc_pkg::FIX_W'(d);
    return a > gbc_pkg::FIX_W'(t);
  endfunction

  gbc_div u_div_x (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                   .dividend(sum_x), .divisor(sample_count), .quotient(mean_x));
  gbc_div u_div_y (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                   .dividend(sum_y), .divisor(sample_count), .quotient(mean_y));
  gbc_div u_div_z (.clk(clk), .load(cmd.div_load), .step(cmd.div_step),
                   .dividend(sum_z), .divisor(sample_count), .quotient(mean_z));

  assign status.at_rest         = rest;
  assign status.count_above_min = (sample_count > gbc_pkg::REJECT_MIN);
  assign status.reject          = exceeds(smp_x, mean_x, threshold) |
                                  exceeds(smp_y, mean_y, threshold) |
                                  exceeds(smp_z, mean_z, threshold);
  assign status.target_hit      = (sample_count >= target);
  assign status.out_free        = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gbc_pkg::THRESHOLD_RST;
      target    <= gbc_pkg::TARGET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gbc_pkg::REG_THRESHOLD: threshold <= cfg_data[gbc_pkg::THR_W-1:0];
        gbc_pkg::REG_TARGET:    target    <= cfg_data[gbc_pkg::TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_x <= rate_x;
      smp_y <= rate_y;
      smp_z <= rate_z;
      rest  <= at_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      sample_count <= '0;
    end else if (cmd.clear_acc) begin
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      sample_count <= '0;
    end else if (cmd.accumulate) begin
      sum_x <= sum_x + gbc_pkg::SUM_W'(smp_x);
      sum_y <= sum_y + gbc_pkg::SUM_W'(smp_y);
      sum_z <= sum_z + gbc_pkg::SUM_W'(smp_z);
      if (sample_count != gbc_pkg::COUNT_MAX) begin
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x  <= gbc_pkg::OFFSET_X_RST;
      offset_y  <= gbc_pkg::OFFSET_Y_RST;
      offset_z  <= gbc_pkg::OFFSET_Z_RST;
      done_flag <= 1'b0;
    end else if (cmd.capture) begin
      done_flag <= 1'b0;
    end else if (cmd.write_offset) begin
      offset_x  <= mean_x;
      offset_y  <= mean_y;
      offset_z  <= mean_z;
      done_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      done_res <= done_flag;
      bias_x   <= offset_x;
      bias_y   <= offset_y;
      bias_z   <= offset_z;
      fixed_x  <= gbc_pkg::FIX_W'(smp_x) - gbc_pkg::FIX_W'(offset_x);
      fixed_y  <= gbc_pkg::FIX_W'(smp_y) - gbc_pkg::FIX_W'(offset_y);
      fixed_z  <= gbc_pkg::FIX_W'(smp_z) - gbc_pkg::FIX_W'(offset_z);
    end
  end

endmodule

@@ sv/gyro_bias_calibrator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the gyro zero-rate bias calibrator: controller, datapath and channels.
// Depends on gbc_pkg, gbc_in_if, gbc_out_if, gbc_ctrl and gbc_datapath.

// The unit works on one sample beat at a time and returns one result beat for each.
// A beat taken while the platform moves goes straight to the hand-off, and a resting
// beat with 20 or fewer samples held is added without a check. With more than 20
// samples held each beat first runs a 24-step deviation check, after which it is
// dropped or kept. A beat that completes a calibration runs a second 24-step pass to
// form the new biases, with or without the check. Both passes use the same three
// per-axis restoring dividers, one quotient bit per cycle. The result beat becomes
// valid in the same cycle in which the next sample beat can be taken; while the
// previous result still waits unread, the controller holds in its last state until
// that beat is taken. A finished result waits in the output register while the next
// sample beat is already accepted. A configuration write also takes effect on a beat
// already in work.
module gyro_bias_calibrator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbc_pkg::CFG_W-1:0]     cfg_data,
  gbc_in_if.sink                        in_ch,
  gbc_out_if.source                     out_ch
);

  gbc_pkg::ctrl_cmd_t  cmd;
  gbc_pkg::dp_status_t status;

  gbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gbc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rate_x    (in_ch.rate_x),
    .rate_y    (in_ch.rate_y),
    .rate_z    (in_ch.rate_z),
    .at_rest   (in_ch.at_rest),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .done_res  (out_ch.done_res),
    .bias_x    (out_ch.bias_x),
    .bias_y    (out_ch.bias_y),
    .bias_z    (out_ch.bias_z),
    .fixed_x   (out_ch.fixed_x),
    .fixed_y   (out_ch.fixed_y),
    .fixed_z   (out_ch.fixed_z)
  );

  assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("A second sample beat was accepted while one was in work.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("The output register was overwritten before its beat was taken.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.out_load))
    else $error("A result beat appeared without a result being loaded.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |-> !cmd.div_step && !cmd.out_load)
    else $error("The dividers were loaded while stepping or handing off a result.");

endmodule
